// ===== rtl/core/ucf_pkg.sv =====
package ucf_pkg;

  localparam int MaxGround = 6;
  localparam int FamW      = 64;
  localparam int IdxW      = 6;
  localparam int CntW      = 7;   // per-cycle check count, up to 63
  localparam int ChkW      = 11;  // per-mask checks, up to 2016
  localparam int TotW      = 32;
  localparam int ItemW     = 16;
  localparam int GsW       = 3;
  localparam int OutDataW  = 64;  // 62 payload bits padded to whole bytes

  localparam logic [GsW-1:0] GroundReset = GsW'(MaxGround);

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new mask
    logic step;    // evaluate one lower subset index
    logic commit;  // write the result register and batch totals
  } ucf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic oor;        // current mask lies outside the ground set
    logic scan_done;  // this step is the last one of the scan
    logic out_free;   // result register can take a new result
  } ucf_sts_t;

  // Subsets allowed by the ground size; sizes above the maximum clamp to it
  function automatic logic [FamW-1:0] legal_subsets(input logic [GsW-1:0] gs);
    logic [FamW-1:0] m;
    case (gs)
      3'd0:    m = 64'h0000_0000_0000_0001;
      3'd1:    m = 64'h0000_0000_0000_0003;
      3'd2:    m = 64'h0000_0000_0000_000F;
      3'd3:    m = 64'h0000_0000_0000_00FF;
      3'd4:    m = 64'h0000_0000_0000_FFFF;
      3'd5:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Result bit h is fam[lo | h]; one mux stage per bit of lo
  function automatic logic [FamW-1:0] or_permute(input logic [FamW-1:0] fam,
                                                 input logic [IdxW-1:0] lo);
    logic [FamW-1:0] v;
    logic [FamW-1:0] w;
    v = fam;
    for (int b = 0; b < IdxW; b++) begin
      for (int h = 0; h < FamW; h++) begin
        w[h] = v[h | (1 << b)];
      end
      if (lo[b]) begin
        v = w;
      end
    end
    return v;
  endfunction

  // Population count: eight byte counts, then their sum
  function automatic logic [CntW-1:0] pop64(input logic [FamW-1:0] x);
    logic [3:0]      part [8];
    logic [CntW-1:0] sum;
    for (int k = 0; k < 8; k++) begin
      part[k] = '0;
      for (int j = 0; j < 8; j++) begin
        part[k] = part[k] + 4'(x[8*k+j]);
      end
    end
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + CntW'(part[k]);
    end
    return sum;
  endfunction

endpackage

// ===== rtl/core/ucf_ctrl.sv =====
module ucf_ctrl import ucf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  ucf_sts_t sts_i,
  output ucf_cmd_t cmd_o
);

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = !sts_i.oor;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is written only where the result register can take it
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit while result register busy");

  // An accepted mask always starts a scan
  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_SCAN)
    else $error("load not followed by scan");

  // An out-of-range mask never steps the scan
  a_oor_nostep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.oor && state_q == ST_SCAN |-> !cmd_o.step)
    else $error("scan step on out-of-range mask");

endmodule

// ===== rtl/core/ucf_dp.sv =====
module ucf_dp import ucf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ucf_cmd_t            cmd_i,
  output ucf_sts_t            sts_o,
  input  logic [FamW-1:0]     fam_i,
  input  logic                first_i,
  input  logic                cfg_we_i,
  input  logic [GsW-1:0]      cfg_data_i,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata
);

  logic [GsW-1:0]  gs_q;
  logic [FamW-1:0] fam_q;
  logic            first_q;
  logic            oor_q;
  logic [IdxW-1:0] lo_q;
  logic [ChkW-1:0] mchk_q;
  logic            closed_q;

  logic [TotW-1:0]  chk_tot_q;
  logic [ItemW-1:0] item_tot_q;
  logic             failed_q;

  logic             out_valid_q;
  logic             out_closed_q;
  logic             out_oor_q;
  logic             out_failed_q;
  logic [ChkW-1:0]  out_mchk_q;

  logic [FamW-1:0] joined;
  logic [FamW-1:0] cand;
  logic [FamW-1:0] miss;
  logic [FamW-1:0] upto;
  logic            miss_any;
  logic [CntW-1:0] step_cnt;

  logic [TotW:0]    chk_sum;
  logic [TotW-1:0]  chk_base;
  logic [TotW-1:0]  chk_tot_d;
  logic [ItemW-1:0] item_base;
  logic [ItemW-1:0] item_tot_d;
  logic             failed_d;

  // Ground size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GroundReset;
    end else if (cfg_we_i) begin
      gs_q <= cfg_data_i;
    end
  end

  // Partners of the current lower index, all checked at once
  always_comb begin
    joined = or_permute(fam_q, lo_q);
    for (int h = 0; h < FamW; h++) begin
      cand[h] = fam_q[lo_q] && fam_q[h] && (IdxW'(h) > lo_q)
                && ((lo_q & ~IdxW'(h)) != '0);
    end
    miss     = cand & ~joined;
    miss_any = (miss != '0);
    upto     = miss ^ (miss - FamW'(1));  // up to and including first miss
    step_cnt = pop64(miss_any ? (cand & upto) : cand);
  end

  // Scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fam_q    <= fam_i;
      first_q  <= first_i;
      oor_q    <= (fam_i & ~legal_subsets(gs_q)) != '0;
      lo_q     <= '0;
      mchk_q   <= '0;
      closed_q <= 1'b1;
    end else if (cmd_i.step) begin
      lo_q   <= lo_q + IdxW'(1);
      mchk_q <= mchk_q + ChkW'(step_cnt);
      if (miss_any) begin
        closed_q <= 1'b0;
      end
    end
  end

  assign sts_o.oor       = oor_q;
  assign sts_o.scan_done = oor_q || miss_any || (lo_q == IdxW'(FamW - 1));
  assign sts_o.out_free  = !out_valid_q || m_tready;

  // Batch totals, saturating
  always_comb begin
    chk_base   = first_q ? '0 : chk_tot_q;
    item_base  = first_q ? '0 : item_tot_q;
    chk_sum    = {1'b0, chk_base} + (TotW+1)'(mchk_q);
    chk_tot_d  = chk_sum[TotW] ? '1 : chk_sum[TotW-1:0];
    item_tot_d = (item_base == '1) ? item_base : item_base + ItemW'(1);
    failed_d   = (failed_q && !first_q) || oor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_tot_q  <= '0;
      item_tot_q <= '0;
      failed_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      chk_tot_q  <= chk_tot_d;
      item_tot_q <= item_tot_d;
      failed_q   <= failed_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_closed_q <= closed_q && !oor_q;
      out_oor_q    <= oor_q;
      out_failed_q <= failed_d;
      out_mchk_q   <= oor_q ? '0 : mchk_q;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {2'b00, item_tot_q, chk_tot_q, out_mchk_q,
                     out_failed_q, out_oor_q, out_closed_q};

  // Per-mask checks stay within the pair count of 64 subsets
  a_mchk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> mchk_q <= ChkW'(2016))
    else $error("mask check count out of bounds");

  // An out-of-range result carries no checks and is never closed
  a_oor_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oor_q |-> out_mchk_q == '0 && !out_closed_q && out_failed_q)
    else $error("out-of-range result inconsistent");

  // After any committed item the item total is nonzero
  a_items_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> item_tot_q != '0)
    else $error("item total zero after commit");

endmodule

// ===== rtl/core/union_closed_family_check_top.sv =====
// Union-closed family check.
// Input stream: s_tdata carries a 64-bit family mask (bit s set = subset s
// is a member), s_tuser carries the first-of-batch flag, which clears the
// batch totals and the failure flag before this item.
// Output stream: one result per input on m_tdata.
// Configuration: cfg_data_i writes the ground size (reset value 6); the
// channel is always ready, and writes belong in idle periods.
// Sequence: after a transfer the scan steps through the lower subset indices
// in order, ending early at the first missing union; an out-of-range mask
// ends the scan at once. The commit then writes the result register when
// it is free, and s_tready returns together with m_tvalid.
// The scan step compares one lower index against all 64 partners at once.
// One item is in work at a time; s_tready is high while the block idles,
// even while a result waits in the output register.
// Stall: a held result stays in m_tdata; a finished scan waits until the
// register drains. Reset clears the totals, the flag and both channels.
module union_closed_family_check_top import ucf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [FamW-1:0]     s_tdata,   // [63:0] family_mask
  input  logic                s_tuser,   // [0] first_of_batch
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] closed, [1] out_of_range, [2] batch_failed, [13:3] mask_pair_checks,
  // [45:14] total_pair_checks, [61:46] items_in_batch, [63:62] zero
  output logic [OutDataW-1:0] m_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [GsW-1:0]      cfg_data_i   // [2:0] ground_count
);

  ucf_cmd_t cmd;
  ucf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ucf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  ucf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .fam_i      (s_tdata),
    .first_i    (s_tuser),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top import ucf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxGap       = 17;
  localparam int PhaseItems   = 175;
  localparam int DrainCycles  = 70;
  localparam int CycleLimit   = 4_000_000;
  localparam int ReportCap    = 40;

  // Result word, lowest field last
  typedef struct packed {
    logic [1:0]       pad;
    logic [ItemW-1:0] items_in_batch;
    logic [TotW-1:0]  total_pair_checks;
    logic [ChkW-1:0]  mask_pair_checks;
    logic             batch_failed;
    logic             out_of_range;
    logic             closed;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [FamW-1:0]     s_tdata;   // [63:0] family_mask
  logic                s_tuser;   // [0] first_of_batch
  logic                m_tvalid;
  logic                m_tready;
  // [0] closed, [1] out_of_range, [2] batch_failed, [13:3] mask_pair_checks,
  // [45:14] total_pair_checks, [61:46] items_in_batch, [63:62] zero
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [GsW-1:0]      cfg_data_i;   // [2:0] ground_count

  // Predictor state
  logic [GsW-1:0]   ground_q;
  logic [TotW-1:0]  check_sum_q;
  logic [ItemW-1:0] item_count_q;
  logic             batch_fail_q;

  verdict_t pending_verdicts[$];
  bit       tx_quiet;
  bit       rx_quiet;
  bit       offered;
  int       err_count;
  longint   cycle_count;

  union_closed_family_check_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Subset indices legal for a ground size; oversize values clamp
  function automatic logic [FamW-1:0] allowed_set(input logic [GsW-1:0] gs);
    int g;
    g = (int'(gs) > MaxGround) ? MaxGround : int'(gs);
    if ((1 << g) >= FamW) return '1;
    return (64'd1 << (1 << g)) - 64'd1;
  endfunction

  // Expected result for one accepted mask; advances the batch totals
  function automatic verdict_t predict_verdict(input logic [FamW-1:0] fam,
                                               input logic first);
    verdict_t   v;
    logic [TotW:0] sum;
    logic       halted;
    v = '0;
    halted = 1'b0;
    if (first) begin
      check_sum_q  = '0;
      item_count_q = '0;
      batch_fail_q = 1'b0;
    end
    v.out_of_range = |(fam & ~allowed_set(ground_q));
    if (v.out_of_range) begin
      batch_fail_q = 1'b1;
    end else begin
      v.closed = 1'b1;
      // lower index outer, higher inner; stop at the first missing union
      for (int lo = 0; lo < FamW; lo++) begin
        if (!halted && fam[lo]) begin
          for (int hi = lo + 1; hi < FamW; hi++) begin
            if (!halted && fam[hi] && ((lo | hi) != hi)) begin
              v.mask_pair_checks = v.mask_pair_checks + 1'b1;
              if (!fam[lo | hi]) begin
                v.closed = 1'b0;
                halted   = 1'b1;
              end
            end
          end
        end
      end
    end
    sum = {1'b0, check_sum_q} + (TotW + 1)'(v.mask_pair_checks);
    check_sum_q = sum[TotW] ? '1 : sum[TotW-1:0];
    if (item_count_q != '1) item_count_q = item_count_q + 1'b1;
    v.batch_failed      = batch_fail_q;
    v.total_pair_checks = check_sum_q;
    v.items_in_batch    = item_count_q;
    return v;
  endfunction

  // One input transfer, after a random gap
  task automatic send_family(input logic [FamW-1:0] fam, input logic first);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      if (offered) begin
        s_tvalid <= 1'b0;
        offered = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= fam;
    s_tuser  <= first;
    offered = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    pending_verdicts.push_back(predict_verdict(fam, first));
  endtask

  // Hold off input until every pending result has come back
  task automatic drain_results();
    if (offered) begin
      s_tvalid <= 1'b0;
      offered = 1'b0;
    end
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Ground size write, only with the block idle
  task automatic write_ground(input logic [GsW-1:0] gs);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= gs;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ground_q = gs;
  endtask

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      err_count++;
      if (err_count <= ReportCap)
        $display("%0t: %s expected %0d actual %0d", $time, fname, want, seen);
    end
  endtask

  // Edge masks at the reset ground size of six
  task automatic test_directed_families();
    send_family(64'h0, 1'b1);                   // empty family
    send_family(64'h1, 1'b0);                   // empty set only
    send_family('1, 1'b0);                      // full power set, most checks
    send_family(64'h8000_0000_0000_0000, 1'b0); // single top subset
    send_family(64'h6, 1'b0);                   // {0},{1} without {0,1}
    send_family(64'hA, 1'b0);                   // nested pair is skipped
    send_family(64'h7FFF_FFFF_FFFF_FFFF, 1'b0); // missing top fails at lower index 1
    send_family(64'hFFFF_FFFF_FFFF_FFFE, 1'b0); // closed without empty set
  endtask

  // Ground size extremes and out-of-range masks
  task automatic test_ground_extremes();
    write_ground(3'd0);
    send_family(64'h1, 1'b1);
    send_family(64'h2, 1'b0);
    send_family(64'h0, 1'b0);
    write_ground(3'd7);                         // clamps to six
    send_family('1, 1'b1);
    write_ground(3'd5);
    send_family(64'h1_0000_0000, 1'b1);
    send_family(64'hFFFF_FFFF, 1'b0);
  endtask

  // Sticky failure flag and its clear on a new batch
  task automatic test_batch_flag();
    write_ground(3'd2);
    send_family(64'h10, 1'b1);
    send_family(64'hF, 1'b0);
    send_family(64'hF, 1'b1);
  endtask

  // Random families: mostly union-closed, some broken, some noise
  task automatic test_random_families();
    logic [GsW-1:0]  phase_gs [8];
    logic [FamW-1:0] ok_set;
    logic [FamW-1:0] fam;
    logic [FamW-1:0] grown;
    int cnt;
    int pick;
    int n;
    int idx;
    phase_gs = '{3'd6, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd2};
    for (int p = 0; p < 8; p++) begin
      write_ground(phase_gs[p]);
      ok_set = allowed_set(phase_gs[p]);
      cnt = (int'(phase_gs[p]) >= MaxGround) ? FamW : (1 << phase_gs[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 25 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if (k == PhaseItems / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // union closure of a few random generators
          fam = '0;
          n = $urandom_range(1, 8);
          for (int g = 0; g < n; g++) begin
            idx = $urandom_range(0, cnt - 1);
            grown = fam;
            for (int s = 0; s < FamW; s++) begin
              if (fam[s]) grown[s | idx] = 1'b1;
            end
            grown[idx] = 1'b1;
            fam = grown;
          end
          if ($urandom_range(0, 3) == 0) fam[0] = 1'b1;
          // flip one subset bit, which can break closure
          if (pick >= 50) begin
            idx = $urandom_range(0, cnt - 1);
            fam[idx] = ~fam[idx];
          end
        end else if (pick < 85) begin
          fam = {$urandom, $urandom} & ok_set;
        end else if (pick < 95 && cnt < FamW) begin
          fam = ({$urandom, $urandom} & ok_set) |
                (64'd1 << $urandom_range(cnt, FamW - 1));
        end else begin
          fam = {$urandom, $urandom};
        end
        send_family(fam, (k == 0) || ($urandom_range(0, 19) == 0));
      end
    end
    drain_results();
  endtask

  // Main sequence
  initial begin
    rst_ni      <= 1'b0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    offered      = 1'b0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    err_count    = 0;
    ground_q     = GroundReset;
    check_sum_q  = '0;
    item_count_q = '0;
    batch_fail_q = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_families();
    test_ground_extremes();
    test_batch_flag();
    test_random_families();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stall before each result, none in quiet stretches
  initial begin
    int stall;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    verdict_t want;
    verdict_t seen;
    if (rst_ni && m_tvalid && m_tready) begin
      seen = verdict_t'(m_tdata);
      if (pending_verdicts.size() == 0) begin
        err_count++;
        if (err_count <= ReportCap)
          $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("closed", want.closed, seen.closed);
        compare_field("out_of_range", want.out_of_range, seen.out_of_range);
        compare_field("batch_failed", want.batch_failed, seen.batch_failed);
        compare_field("mask_pair_checks", want.mask_pair_checks, seen.mask_pair_checks);
        compare_field("total_pair_checks", want.total_pair_checks,
                      seen.total_pair_checks);
        compare_field("items_in_batch", want.items_in_batch, seen.items_in_batch);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
